### rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int KEY_BYTES_DEF   = 8;

   localparam int KEY_W   = 64;
   localparam int SCORE_W = 16;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [SLOT_W-1:0]  load_index;
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score_in;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [SLOT_W-1:0]  match_index;
      logic [SCORE_W-1:0] score_out;
   } rsp_type;

endpackage

### rtl/stbs_table.sv
// ----------------------------------------------------------------------------
// stbs_table
// Key and score storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module stbs_table import stbs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int IDX_W       = $clog2(MAX_ENTRIES)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [KEY_W-1:0]   wr_key,
   input  logic [SCORE_W-1:0] wr_score,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [KEY_W-1:0]   rd_key,
   output logic [SCORE_W-1:0] rd_score
);

   logic [KEY_W-1:0]   key_mem   [MAX_ENTRIES];
   logic [SCORE_W-1:0] score_mem [MAX_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         score_mem[wr_addr] <= wr_score;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key   <= key_mem[rd_addr];
         rd_score <= score_mem[rd_addr];
      end
   end

endmodule

### rtl/stbs_search.sv
// ----------------------------------------------------------------------------
// stbs_search
// Request decode and probe sequencer: writes loads into the table and walks
// a halving search over [lo, hi), one table read per probe.
// ----------------------------------------------------------------------------
module stbs_search import stbs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int KEY_BYTES   = KEY_BYTES_DEF,
   parameter int IDX_W       = $clog2(MAX_ENTRIES),
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   input  logic [CNT_W-1:0]   count,
   output logic               rsp_valid,
   output rsp_type            rsp_item,
   output logic               wr_en,
   output logic [IDX_W-1:0]   wr_addr,
   output logic [KEY_W-1:0]   wr_key,
   output logic [SCORE_W-1:0] wr_score,
   output logic               rd_en,
   output logic [IDX_W-1:0]   rd_addr,
   input  logic [KEY_W-1:0]   rd_key,
   input  logic [SCORE_W-1:0] rd_score
);

   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
      KEY_W'((65'd1 << (8 * KEY_BYTES)) - 65'd1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_CMP   = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [KEY_W-1:0]   target_ff, target_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic               accept;
   logic [CNT_W-1:0]   mid_calc;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign mid_calc = lo_ff + ((hi_ff - lo_ff - CNT_W'(1)) >> 1);

   // loads go straight into the table at the accepting edge
   assign wr_en    = accept && (req_item.mode == MODE_LOAD) &&
                     (32'(req_item.load_index) < 32'(MAX_ENTRIES));
   assign wr_addr  = IDX_W'(req_item.load_index);
   assign wr_key   = req_item.key & KEY_MASK;
   assign wr_score = req_item.score_in;

   assign rd_en    = (state_ff == ST_PROBE) && (lo_ff < hi_ff);
   assign rd_addr  = mid_calc[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      target_in    = target_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_item.mode == MODE_SEARCH)) begin
               lo_in     = '0;
               hi_in     = count;
               target_in = req_item.key & KEY_MASK;
               state_in  = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               state_in = ST_CMP;
            end else begin
               // range empty: report a miss
               rsp_valid_in = 1'b1;
               rsp_item_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (rd_key == target_ff) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.found       = 1'b1;
               rsp_item_in.match_index = SLOT_W'(mid_ff);
               rsp_item_in.score_out   = rd_score;
               state_in                = ST_IDLE;
            end else begin
               if (rd_key < target_ff) begin
                  lo_in = mid_ff + CNT_W'(1);
               end else begin
                  hi_in = mid_ff;
               end
               state_in = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      target_ff   <= target_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### rtl/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted key table with a binary search lookup.
//
// Requests enter on start/req_item while busy is low. A load request
// (mode 0) writes key and score into slot load_index at the accepting edge;
// it gives no response and the core stays idle, ready for the next
// request. A search request (mode 1) searches the first entry_count slots,
// one registered table read per probe, each probe passing through the
// ST_PROBE and ST_CMP states of the sequencer. busy drops in the strobe cycle,
// so the next request is taken at the edge that ends it and the probe
// loop through the table read port sets the throughput. rsp_valid is
// high for exactly one cycle; rsp_item holds the response until the
// next response, and the receiver cannot stall it.
// The csr channel writes entry_count (always ready); write it only while
// idle. Values above MAX_ENTRIES are clamped. Reset clears entry_count and
// the sequencer; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core import stbs_pkg::*; #(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
   parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_valid,
   output rsp_type            rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]   count_sat;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_key;
   logic [SCORE_W-1:0] wr_score;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_key;
   logic [SCORE_W-1:0] rd_score;

   assign csr_ready      = 1'b1;
   assign entry_count_in = (csr_valid && csr_ready) ? csr_data : entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // clamp to the table depth
   assign count_sat = (32'(entry_count_ff) > 32'(MAX_ENTRIES)) ?
                      CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count_ff);

   stbs_search #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BYTES   (KEY_BYTES),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .count     (count_sat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_key    (wr_key),
      .wr_score  (wr_score),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_score  (rd_score)
   );

   stbs_table #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_score (wr_score),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_score (rd_score)
   );

endmodule

### verif/sorted_table_binary_search_core_test.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core_test
// Self-checking bench for the sorted table binary search core.
//
// A short table of directed requests covers the count extremes, hits and
// misses at the table ends, and an unsorted table. Then random phases follow,
// each under a new entry count, with the table filled in nondecreasing order
// before every third one, mixing searches for stored keys, near misses,
// random keys and table rewrites. Every response is compared against a local
// model of the probe sequence or a fixed expected response.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core_test import stbs_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQUEST_GOAL = 950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 38;
   localparam int DRAIN_CYCLES = 16;

   localparam logic [KEY_W-1:0] KEY_A  = 64'h4100_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_AB = 64'h4142_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_B  = 64'h4200_0000_0000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;

   typedef enum logic {ROW_REQUEST, ROW_COUNT} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [COUNT_W-1:0] count;
      req_type            req;
      bit                 typed;
      rsp_type            rsp;
   } dir_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start;
   logic               busy;
   req_type            req_item;
   logic               rsp_valid;
   rsp_type            rsp_item;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   // local copy of the table and the searched entry count
   logic [KEY_W-1:0]   table_key   [MAX_ENTRIES_DEF];
   logic [SCORE_W-1:0] table_score [MAX_ENTRIES_DEF];
   logic [COUNT_W-1:0] table_count;

   rsp_type pending_rsp[$];

   bit quiet;
   int cycles = 0;
   int sent;
   int searches;
   int checked = 0;
   int mismatches = 0;
   int fills;

   sorted_table_binary_search_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, pending_rsp.size());
         $display("FAIL");
         $finish;
      end
   end

   // Walk the same halving probe sequence as the core.
   function automatic rsp_type search_table(input logic [KEY_W-1:0] target);
      rsp_type r;
      int      lo;
      int      hi;
      int      mid;
      r  = '0;
      lo = 0;
      hi = (table_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(table_count);
      while (lo < hi) begin
         mid = lo + (hi - 1 - lo) / 2;
         if (table_key[mid[SLOT_W-1:0]] == target) begin
            r.found       = 1'b1;
            r.match_index = mid[SLOT_W-1:0];
            r.score_out   = table_score[mid[SLOT_W-1:0]];
            return r;
         end
         if (table_key[mid[SLOT_W-1:0]] < target)
            lo = mid + 1;
         else
            hi = mid;
      end
      return r;
   endfunction

   function automatic dir_row_type row(input row_kind_type kind,
                                       input logic [COUNT_W-1:0] count,
                                       input req_type req, input bit typed,
                                       input rsp_type rsp);
      dir_row_type d;
      d.kind  = kind;
      d.count = count;
      d.req   = req;
      d.typed = typed;
      d.rsp   = rsp;
      return d;
   endfunction

   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(99) < IDLE_PCT)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      if (r.mode == MODE_SEARCH) begin
         pending_rsp.push_back(typed ? typed_rsp : search_table(r.key));
         searches++;
      end else begin
         table_key[r.load_index]   = r.key;
         table_score[r.load_index] = r.score_in;
      end
      sent++;
   endtask

   // Change the entry count only once the core has gone quiet.
   task automatic set_count(input logic [COUNT_W-1:0] value);
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      table_count = value;
   endtask

   // Load all slots with nondecreasing keys, with some duplicates and at times
   // the key extremes at the ends.
   task automatic fill_sorted_table();
      logic [KEY_W-1:0]  k;
      logic [SLOT_W-1:0] s;
      req_type           r;
      k = '0;
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
         s = i[SLOT_W-1:0];
         if (i == 0 && $urandom_range(3) == 0)
            k = '0;
         else if (i == MAX_ENTRIES_DEF - 1 && $urandom_range(3) == 0)
            k = KEY_MAX;
         else if (i == 0 || $urandom_range(15) != 0)
            k = {s, 26'($urandom), 32'($urandom)};
         r.mode       = MODE_LOAD;
         r.load_index = s;
         r.key        = k;
         r.score_in   = 16'($urandom);
         send_request(r, 1'b0, '0);
      end
      fills++;
   endtask

   task automatic record_mismatch(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s: exp found=%0b idx=%0d score=%h, got found=%0b idx=%0d score=%h",
                  $realtime, what, want.found, want.match_index, want.score_out,
                  got.found, got.match_index, got.score_out);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            record_mismatch("response with no search pending", '0, rsp_item);
         end else begin
            want = pending_rsp.pop_front();
            checked++;
            if (rsp_item.found !== want.found || rsp_item.match_index !== want.match_index ||
                rsp_item.score_out !== want.score_out)
               record_mismatch("search response mismatch", want, rsp_item);
         end
      end
   end

   initial begin
      dir_row_type        dir_rows[$];
      req_type            r;
      int                 n;
      int                 pick;
      int                 phase;
      int                 phase_len;
      int                 random_sent;
      logic [COUNT_W-1:0] cnt;

      start      = 1'b0;
      req_item   = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      quiet      = 1'b0;
      sent       = 0;
      searches   = 0;
      fills      = 0;
      table_count = '0;
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
         table_key[i[SLOT_W-1:0]]   = '0;
         table_score[i[SLOT_W-1:0]] = '0;
      end

      // count zero right after reset: nothing is probed
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, 64'd0, 16'd0}),
                             1'b1, rsp_type'({1'b0, 6'd0, 16'h0000})));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_LOAD, 6'd0, 64'd0, 16'hFFFF}), 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_LOAD, 6'd1, KEY_A, 16'h0001}), 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_LOAD, 6'd2, KEY_AB, 16'h1234}), 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_LOAD, 6'd3, KEY_MAX, 16'h0000}), 1'b0, '0));
      dir_rows.push_back(row(ROW_COUNT, 7'd4, '0, 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, 64'd0, 16'd0}),
                             1'b1, rsp_type'({1'b1, 6'd0, 16'hFFFF})));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_MAX, 16'd0}),
                             1'b1, rsp_type'({1'b1, 6'd3, 16'h0000})));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd5, KEY_AB, 16'hFFFF}), 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_A, 16'd0}), 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd63, KEY_B, 16'd0}),
                             1'b1, rsp_type'({1'b0, 6'd0, 16'h0000})));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_A + 64'd1, 16'd0}),
                             1'b1, rsp_type'({1'b0, 6'd0, 16'h0000})));
      // break the ordering: slot 1 now holds a key above slot 2
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_LOAD, 6'd1, KEY_MAX - 64'd1, 16'hBEEF}),
                             1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_MAX - 64'd1, 16'd0}),
                             1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_AB, 16'd0}), 1'b0, '0));
      dir_rows.push_back(row(ROW_COUNT, 7'd1, '0, 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, 64'd0, 16'd0}),
                             1'b1, rsp_type'({1'b1, 6'd0, 16'hFFFF})));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_AB, 16'd0}),
                             1'b1, rsp_type'({1'b0, 6'd0, 16'h0000})));
      dir_rows.push_back(row(ROW_COUNT, 7'd0, '0, 1'b0, '0));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_SEARCH, 6'd0, KEY_MAX, 16'd0}),
                             1'b1, rsp_type'({1'b0, 6'd0, 16'h0000})));
      dir_rows.push_back(row(ROW_REQUEST, 7'd0,
                             req_type'({MODE_LOAD, 6'd63, KEY_MAX, 16'hFFFF}), 1'b0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_COUNT)
            set_count(dir_rows[i].count);
         else
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      end

      // random phases; the first one checks an oversized count
      random_sent = 0;
      phase = 0;
      while (random_sent < REQUEST_GOAL) begin
         if (phase % 3 == 0) begin
            start <= 1'b0;
            n = sent;
            fill_sorted_table();
            random_sent += sent - n;
         end
         if (phase == 0) begin
            cnt = 7'd127;
         end else begin
            case ($urandom_range(7))
               0: cnt = 7'd0;
               1: cnt = 7'd1;
               2: cnt = 7'd2;
               3: cnt = 7'd63;
               4: cnt = 7'd64;
               5: cnt = 7'($urandom_range(65, 127));
               default: cnt = 7'($urandom_range(0, 127));
            endcase
         end
         set_count(cnt);
         quiet = (phase == 2) || ($urandom_range(3) == 0);
         n = (cnt > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(cnt);
         phase_len = $urandom_range(30, 80);
         for (int j = 0; j < phase_len; j++) begin
            pick = $urandom_range(99);
            r.load_index = 6'($urandom);
            r.score_in   = 16'($urandom);
            if (pick < 20) begin
               // rewrite a slot: keep its key half the time, else random noise
               r.mode = MODE_LOAD;
               r.key  = $urandom_range(1) ? table_key[r.load_index]
                                          : {32'($urandom), 32'($urandom)};
            end else begin
               r.mode = MODE_SEARCH;
               if (n > 0 && pick < 68)
                  r.key = table_key[SLOT_W'($urandom_range(n - 1))];
               else if (n > 0 && pick < 82)
                  r.key = table_key[SLOT_W'($urandom_range(n - 1))] +
                          ($urandom_range(1) ? 64'd1 : '1);
               else
                  r.key = {32'($urandom), 32'($urandom)};
            end
            send_request(r, 1'b0, '0);
            random_sent++;
         end
         phase++;
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests in %0d phases: %0d searches, %0d responses checked",
               sent, phase, searches, checked);
      $display("%0d sorted table fills, %0d mismatches", fills, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### files.f
rtl/stbs_pkg.sv
rtl/stbs_table.sv
rtl/stbs_search.sv
rtl/sorted_table_binary_search_core.sv
verif/sorted_table_binary_search_core_test.sv
